// ===== rtl/core/dstu_pkg.sv =====
// Shared types, constants and helpers for the string-field to UTF-8 decoder.
package dstu_pkg;

    // Header codes of the tagged string field
    localparam logic [7:0] HDR_LONG_ASCII = 8'h40;
    localparam logic [7:0] HDR_LONG_UTF16 = 8'h90;

    // Long header length counts its own four bytes
    localparam logic [15:0] LONG_HDR_LEN = 16'd4;

    // UTF-8 encoding limits and lead/continuation marks
    localparam logic [15:0] UTF8_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] UTF8_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;

    // Most results one input byte can cause
    localparam int unsigned MAX_RESULTS = 3;

    // One input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       string_start;
        logic       region_end;
    } in_t;

    // One output request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_string;
        logic       error_flag;
    } out_t;

    // Results of one input byte, handed from the parser to the output buffer
    typedef struct packed {
        logic [1:0]                 count;
        out_t [MAX_RESULTS-1:0]     res;
    } grp_t;

    // End marker with no text byte
    function automatic out_t close_res(input logic err);
        out_t r;
        r.out_byte      = 8'h00;
        r.has_byte      = 1'b0;
        r.end_of_string = 1'b1;
        r.error_flag    = err;
        return r;
    endfunction

    // Text byte, optionally the last of its string
    function automatic out_t text_res(input logic [7:0] b, input logic last);
        out_t r;
        r.out_byte      = b;
        r.has_byte      = 1'b1;
        r.end_of_string = last;
        r.error_flag    = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/dstu_parse.sv =====
// Header/body parser: holds the string state and decodes one byte into its results.
module dstu_parse (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  dstu_pkg::in_t item,
    output dstu_pkg::grp_t grp
);
    import dstu_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LHDR  = 3'd1,
        PH_ABODY = 3'd2,
        PH_ULOW  = 3'd3,
        PH_UHIGH = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SHORT  = 2'd0,
        KIND_LASCII = 2'd1,
        KIND_UTF16  = 2'd2
    } kind_t;

    phase_t      phase_reg, phase_next;
    kind_t       kind_reg, kind_next;
    logic [1:0]  hpos_reg, hpos_next;
    logic [15:0] brem_reg, brem_next;
    logic [7:0]  low_reg, low_next;

    out_t [MAX_RESULTS-1:0] res;
    logic [1:0]  n;
    logic [15:0] unit;
    logic [15:0] long_len;
    logic [15:0] long_body;
    logic [15:0] brem_dec;
    logic [6:0]  short_len;
    logic        last;

    assign unit      = {item.data_byte, low_reg};
    assign long_len  = unit;
    assign long_body = long_len - LONG_HDR_LEN;
    assign brem_dec  = brem_reg - 16'd1;
    assign short_len = item.data_byte[7:1];

    // Decode one byte against the current state
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        hpos_next  = hpos_reg;
        brem_next  = brem_reg;
        low_next   = low_reg;
        res        = '0;
        n          = 2'd0;
        last       = 1'b0;

        if (item.string_start)
        begin
            // an open string is closed as cut short first
            if (phase_reg != PH_IDLE)
            begin
                res[n] = close_res(kind_reg != KIND_UTF16);
                n      = n + 2'd1;
            end
            phase_next = PH_IDLE;
            hpos_next  = 2'd0;
            if (item.data_byte == HDR_LONG_ASCII || item.data_byte == HDR_LONG_UTF16)
            begin
                kind_next  = (item.data_byte == HDR_LONG_ASCII) ? KIND_LASCII : KIND_UTF16;
                phase_next = PH_LHDR;
                hpos_next  = 2'd1;
                if (item.region_end)
                begin
                    res[n]     = close_res(kind_next != KIND_UTF16);
                    n          = n + 2'd1;
                    phase_next = PH_IDLE;
                end
            end
            else
            begin
                kind_next = KIND_SHORT;
                if (short_len == 7'd0)
                begin
                    res[n] = close_res(1'b1);
                    n      = n + 2'd1;
                end
                else if (short_len == 7'd1)
                begin
                    res[n] = close_res(1'b0);
                    n      = n + 2'd1;
                end
                else if (item.region_end)
                begin
                    res[n] = close_res(1'b1);
                    n      = n + 2'd1;
                end
                else
                begin
                    brem_next  = {9'd0, short_len - 7'd1};
                    phase_next = PH_ABODY;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LHDR:
                begin
                    if (hpos_reg == 2'd1)
                    begin
                        low_next  = item.data_byte;
                        hpos_next = 2'd2;
                        if (item.region_end)
                        begin
                            res[n]     = close_res(kind_reg != KIND_UTF16);
                            n          = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (hpos_reg == 2'd2)
                    begin
                        if (long_len < LONG_HDR_LEN)
                        begin
                            res[n]     = close_res(kind_reg != KIND_UTF16);
                            n          = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            // UTF-16 body holds whole code units only
                            brem_next = (kind_reg == KIND_UTF16) ?
                                        {long_body[15:1], 1'b0} : long_body;
                            hpos_next = 2'd3;
                            if (item.region_end)
                            begin
                                res[n]     = close_res(kind_reg != KIND_UTF16);
                                n          = n + 2'd1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        // pad byte
                        if (brem_reg == 16'd0)
                        begin
                            res[n]     = close_res(1'b0);
                            n          = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else if (item.region_end)
                        begin
                            res[n]     = close_res(kind_reg != KIND_UTF16);
                            n          = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next = (kind_reg == KIND_UTF16) ? PH_ULOW : PH_ABODY;
                        end
                    end
                end

                PH_ABODY:
                begin
                    brem_next = brem_dec;
                    if (brem_dec == 16'd0)
                    begin
                        res[n]     = text_res(item.data_byte, 1'b1);
                        n          = n + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        res[n] = text_res(item.data_byte, 1'b0);
                        n      = n + 2'd1;
                        if (item.region_end)
                        begin
                            res[n]     = close_res(kind_reg != KIND_UTF16);
                            n          = n + 2'd1;
                            phase_next = PH_IDLE;
                        end
                    end
                end

                PH_ULOW:
                begin
                    low_next   = item.data_byte;
                    brem_next  = brem_dec;
                    phase_next = PH_UHIGH;
                    if (item.region_end)
                    begin
                        res[n]     = close_res(kind_reg != KIND_UTF16);
                        n          = n + 2'd1;
                        phase_next = PH_IDLE;
                    end
                end

                PH_UHIGH:
                begin
                    brem_next = brem_dec;
                    if (unit == 16'd0)
                    begin
                        // zero unit ends the string early
                        res[n]     = close_res(1'b0);
                        n          = n + 2'd1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        last = (brem_dec == 16'd0) || item.region_end;
                        if (unit < UTF8_ONE_LIMIT)
                        begin
                            res[n] = text_res(unit[7:0], last);
                            n      = n + 2'd1;
                        end
                        else if (unit < UTF8_TWO_LIMIT)
                        begin
                            res[n] = text_res(UTF8_LEAD2 | {3'd0, unit[10:6]}, 1'b0);
                            n      = n + 2'd1;
                            res[n] = text_res(UTF8_CONT | ({2'd0, unit[5:0]} & UTF8_CONT_MASK),
                                              last);
                            n      = n + 2'd1;
                        end
                        else
                        begin
                            res[n] = text_res(UTF8_LEAD3 | {4'd0, unit[15:12]}, 1'b0);
                            n      = n + 2'd1;
                            res[n] = text_res(UTF8_CONT | {2'd0, unit[11:6]}, 1'b0);
                            n      = n + 2'd1;
                            res[n] = text_res(UTF8_CONT | ({2'd0, unit[5:0]} & UTF8_CONT_MASK),
                                              last);
                            n      = n + 2'd1;
                        end
                        phase_next = last ? PH_IDLE : PH_ULOW;
                    end
                end

                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign grp.count = n;
    assign grp.res   = res;

    // String state, updated per accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            kind_reg  <= KIND_SHORT;
            hpos_reg  <= 2'd0;
            brem_reg  <= 16'd0;
            low_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            hpos_reg  <= hpos_next;
            brem_reg  <= brem_next;
            low_reg   <= low_next;
        end
    end

endmodule

// ===== rtl/core/dstu_obuf.sv =====
// Result buffer: holds the results of one byte and drains them one per cycle while out_ready is high.
module dstu_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  dstu_pkg::grp_t grp,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output dstu_pkg::out_t out_item
);
    import dstu_pkg::*;

    out_t [MAX_RESULTS-1:0] slot_reg;
    logic [1:0]             cnt_reg;
    logic                   pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = slot_reg[0];
    assign pop       = out_valid && out_ready;
    // new group may enter as the last held result leaves
    assign room      = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    // Occupancy count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= grp.count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result slots, shifted toward slot 0 on each pop
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= grp.res;
        end
        else if (pop)
        begin
            slot_reg <= {out_t'('0), slot_reg[MAX_RESULTS-1:1]};
        end
    end

endmodule

// ===== rtl/core/device_string_to_utf8.sv =====
// Top level of the tagged string field to UTF-8 decoder.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) takes one raw byte of a tagged
//   string field per request, with string_start on the header byte and
//   region_end on the last byte of the data region.
//   Output channel (out_valid/out_ready/out_item) gives one result per
//   request: a UTF-8 or ASCII byte, or an end marker, with end_of_string and
//   error_flag. A set error_flag tells the consumer to drop the string.
// Timing: the first result of a byte shows on out_valid in the cycle after the byte is taken.
// Flow: the parser handles one byte per cycle while in_ready is high; the
//   result buffer holds the up to three results of one byte and sends one per
//   cycle while out_ready is high. A byte that makes several results holds off
//   the next byte until its last result leaves the buffer, so a UTF-16 string
//   of 3-byte characters runs slower than ASCII text.
// Reset: clears the parser to idle and empties the result buffer.
// Stall: while out_ready is low the held results stay put and in_ready drops
//   once the buffer cannot take the results of the next byte.
module device_string_to_utf8 (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dstu_pkg::in_t  in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output dstu_pkg::out_t out_item
);
    import dstu_pkg::*;

    grp_t grp;
    logic accept;

    assign accept = in_valid && in_ready;

    dstu_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_item),
        .grp    (grp)
    );

    dstu_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .grp       (grp),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
